// ----- rtl/core/pcss_pkg.sv -----
package pcss_pkg;

  // Sizes of the stacks and of the words they hold.
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned NUM_CLASSES = 3;
  localparam int unsigned MAX_RUN     = 64;
  localparam int unsigned CLS_W       = 2;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned TAG_W       = 32;
  localparam int unsigned WORD_W      = 2 * TAG_W;
  localparam int unsigned FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int unsigned STORE_DEPTH = NUM_CLASSES * STACK_DEPTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned RUN_W       = $clog2(MAX_RUN + 1);

  typedef logic [CLS_W-1:0]  cls_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Class codes.
  localparam cls_t CLS_HIGH    = 2'd0;
  localparam cls_t CLS_MID     = 2'd1;
  localparam cls_t CLS_LOW     = 2'd2;
  localparam cls_t CLS_INVALID = 2'd3;

  typedef enum logic {
    REQ_PUSH  = 1'b0,
    REQ_SERVE = 1'b1
  } req_e;

  typedef enum logic {
    STAT_SERVED  = 1'b0,
    STAT_DROPPED = 1'b1
  } stat_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } seq_state_e;

  // Request to the fill count unit.
  typedef struct packed {
    logic push;
    logic pop;
    cls_t cls;
  } fill_cmd_t;

  // Answers of the fill count unit for the current request.
  typedef struct packed {
    logic  full;
    logic  any;
    cls_t  sel;
    addr_t addr;
    logic  drain;
  } fill_stat_t;

  // Access to the entry store.
  typedef struct packed {
    logic  wr_en;
    logic  rd_en;
    addr_t addr;
  } ram_cmd_t;

  // First slot of a class in the entry store.
  function automatic addr_t base_of(cls_t cls);
    addr_t base;
    case (cls)
      CLS_HIGH: base = '0;
      CLS_MID:  base = ADDR_W'(STACK_DEPTH);
      default:  base = ADDR_W'(2 * STACK_DEPTH);
    endcase
    return base;
  endfunction

endpackage

// ----- rtl/core/priority_class_stack_server_core.sv -----
// Strict-priority server over three LIFO stacks (class 0 highest, then 1, then 2).
//
// Input channel (in_valid_i/in_ready_o): each word is either a push of one
// name/date pair onto the stack of its class, or a serve of up to 64 pops.
// Output channel (out_valid_o/out_ready_i): one word per served entry, or one
// word with status set when a push meets a full stack; last_of_run_o marks the
// final word caused by a request. Pushes with class 3, serves of zero and
// serves with all stacks empty give no word.
//
// Timing: pushes may follow back to back. Each pop of a serve passes through a
// read state, which reads the entry store (a single-port memory with
// registered read), and a send state, which loads the output register; the
// input is held while a serve runs. The input
// is taken again once the run ends and the output register is free.
//
// Receiver stall: words wait in the output register and the sequencer holds
// its place until the register is free; nothing is lost or repeated.
// Reset: all stacks are empty and no word is pending. The entry store itself
// is not cleared; only slots below each fill count are ever read.
module priority_class_stack_server_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [pcss_pkg::CLS_W-1:0]    entry_class_i,
  input  logic [pcss_pkg::TAG_W-1:0]    name_tag_i,
  input  logic [pcss_pkg::TAG_W-1:0]    date_word_i,
  input  logic [pcss_pkg::COUNT_W-1:0]  serve_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_status_o,
  output logic [pcss_pkg::CLS_W-1:0]    out_class_o,
  output logic [pcss_pkg::TAG_W-1:0]    out_name_tag_o,
  output logic [pcss_pkg::TAG_W-1:0]    out_date_word_o,
  output logic                          last_of_run_o
);
  import pcss_pkg::*;

  fill_cmd_t         fill_cmd;
  fill_stat_t        fill_stat;
  ram_cmd_t          ram_cmd;
  logic [WORD_W-1:0] ram_wr_data;
  logic [WORD_W-1:0] ram_rd_data;

  // Sequencer and output register.
  pcss_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .entry_class_i   (entry_class_i),
    .name_tag_i      (name_tag_i),
    .date_word_i     (date_word_i),
    .serve_count_i   (serve_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_status_o    (out_status_o),
    .out_class_o     (out_class_o),
    .out_name_tag_o  (out_name_tag_o),
    .out_date_word_o (out_date_word_o),
    .last_of_run_o   (last_of_run_o),
    .fill_cmd_o      (fill_cmd),
    .fill_stat_i     (fill_stat),
    .ram_cmd_o       (ram_cmd),
    .ram_wr_data_o   (ram_wr_data),
    .ram_rd_data_i   (ram_rd_data)
  );

  // Fill counts, priority pick and slot address.
  pcss_fill u_fill (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (fill_cmd),
    .stat_o (fill_stat)
  );

  // Entry store: name in the high half, date in the low half.
  pcss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_cmd.wr_en),
    .wr_addr_i (ram_cmd.addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_cmd.rd_en),
    .rd_addr_i (ram_cmd.addr),
    .rd_data_o (ram_rd_data)
  );

endmodule

// ----- rtl/core/pcss_ram.sv -----
module pcss_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/pcss_fill.sv -----
module pcss_fill (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pcss_pkg::fill_cmd_t   cmd_i,
  output pcss_pkg::fill_stat_t  stat_o
);
  import pcss_pkg::*;

  logic [FILL_W-1:0] fill_q [NUM_CLASSES];
  logic [FILL_W-1:0] fill_d [NUM_CLASSES];
  logic [FILL_W-1:0] op_fill;
  logic [FILL_W-1:0] op_inc;
  logic [FILL_W-1:0] op_dec;
  cls_t              op_cls;
  cls_t              sel;
  logic              any;
  logic              drain;

  // Highest-priority class that holds an entry.
  always_comb begin
    sel = CLS_INVALID;
    any = 1'b0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (fill_q[c] != '0) begin
        sel = CLS_W'(c);
        any = 1'b1;
      end
    end
  end

  // The shared count increment and decrement work on the class being pushed or popped.
  assign op_cls = cmd_i.pop ? sel : cmd_i.cls;

  always_comb begin
    case (op_cls)
      CLS_HIGH: op_fill = fill_q[0];
      CLS_MID:  op_fill = fill_q[1];
      CLS_LOW:  op_fill = fill_q[2];
      default:  op_fill = '0;
    endcase
  end

  assign op_inc = op_fill + FILL_W'(1);
  assign op_dec = op_fill - FILL_W'(1);

  // True when the pop now in hand empties the last stack.
  always_comb begin
    drain = 1'b1;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (CLS_W'(c) == sel) begin
        if (op_dec != '0) drain = 1'b0;
      end else if (fill_q[c] != '0) begin
        drain = 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.full  = (op_fill == FILL_W'(STACK_DEPTH));
    stat_o.any   = any;
    stat_o.sel   = sel;
    stat_o.addr  = base_of(op_cls) + ADDR_W'(cmd_i.pop ? op_dec : op_fill);
    stat_o.drain = drain;
  end

  // Count update.
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      fill_d[c] = fill_q[c];
      if (op_cls == CLS_W'(c)) begin
        if (cmd_i.push) fill_d[c] = op_inc;
        if (cmd_i.pop)  fill_d[c] = op_dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) fill_q[c] <= '0;
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) fill_q[c] <= fill_d[c];
    end
  end

  // A count never passes the stack depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[0] <= FILL_W'(STACK_DEPTH) && fill_q[1] <= FILL_W'(STACK_DEPTH) &&
    fill_q[2] <= FILL_W'(STACK_DEPTH))
    else $error("fill count above stack depth");

  // A pop is only asked for while some stack holds an entry, and never with a push.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (any && !cmd_i.push))
    else $error("pop with all stacks empty or together with a push");

  // A push never lands on a full stack or uses class 3.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!stat_o.full && cmd_i.cls != CLS_INVALID))
    else $error("push to a full or invalid stack");

endmodule

// ----- rtl/core/pcss_ctrl.sv -----
module pcss_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [pcss_pkg::CLS_W-1:0]  entry_class_i,
  input  logic [pcss_pkg::TAG_W-1:0]  name_tag_i,
  input  logic [pcss_pkg::TAG_W-1:0]  date_word_i,
  input  logic [pcss_pkg::COUNT_W-1:0] serve_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_status_o,
  output logic [pcss_pkg::CLS_W-1:0]  out_class_o,
  output logic [pcss_pkg::TAG_W-1:0]  out_name_tag_o,
  output logic [pcss_pkg::TAG_W-1:0]  out_date_word_o,
  output logic                        last_of_run_o,
  output pcss_pkg::fill_cmd_t         fill_cmd_o,
  input  pcss_pkg::fill_stat_t        fill_stat_i,
  output pcss_pkg::ram_cmd_t          ram_cmd_o,
  output logic [pcss_pkg::WORD_W-1:0] ram_wr_data_o,
  input  logic [pcss_pkg::WORD_W-1:0] ram_rd_data_i
);
  import pcss_pkg::*;

  seq_state_e        state_q, state_d;
  logic [RUN_W-1:0]  run_q, run_d;
  logic [RUN_W-1:0]  run_req;
  cls_t              cls_q, cls_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic              out_status_q, out_status_d;
  cls_t              out_class_q, out_class_d;
  logic [TAG_W-1:0]  out_name_q, out_name_d;
  logic [TAG_W-1:0]  out_date_q, out_date_d;
  logic              out_last_q, out_last_d;
  logic              out_free;
  logic              in_acc;

  // The output register is free when empty or being taken this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Serve counts above the run limit saturate.
  assign run_req = (serve_count_i > COUNT_W'(MAX_RUN)) ? RUN_W'(MAX_RUN)
                                                       : RUN_W'(serve_count_i);

  // Sequencer: a push is handled in idle, each pop as a read state and a send state.
  always_comb begin
    state_d        = state_q;
    run_d          = run_q;
    cls_d          = cls_q;
    last_d         = last_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_status_d   = out_status_q;
    out_class_d    = out_class_q;
    out_name_d     = out_name_q;
    out_date_d     = out_date_q;
    out_last_d     = out_last_q;
    fill_cmd_o.push = 1'b0;
    fill_cmd_o.pop  = 1'b0;
    fill_cmd_o.cls  = entry_class_i;
    ram_cmd_o.wr_en = 1'b0;
    ram_cmd_o.rd_en = 1'b0;
    ram_cmd_o.addr  = fill_stat_i.addr;
    ram_wr_data_o   = {name_tag_i, date_word_i};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (req_type_i == REQ_PUSH) begin
            if (entry_class_i != CLS_INVALID) begin
              if (fill_stat_i.full) begin
                out_valid_d  = 1'b1;
                out_status_d = STAT_DROPPED;
                out_class_d  = entry_class_i;
                out_name_d   = name_tag_i;
                out_date_d   = date_word_i;
                out_last_d   = 1'b1;
              end else begin
                fill_cmd_o.push = 1'b1;
                ram_cmd_o.wr_en = 1'b1;
              end
            end
          end else if (run_req != '0 && fill_stat_i.any) begin
            run_d   = run_req;
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        fill_cmd_o.pop  = 1'b1;
        ram_cmd_o.rd_en = 1'b1;
        cls_d           = fill_stat_i.sel;
        last_d          = (run_q == RUN_W'(1)) || fill_stat_i.drain;
        run_d           = run_q - RUN_W'(1);
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_SERVED;
          out_class_d  = cls_q;
          out_name_d   = ram_rd_data_i[WORD_W-1:TAG_W];
          out_date_d   = ram_rd_data_i[TAG_W-1:0];
          out_last_d   = last_q;
          state_d      = last_q ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result word and run bookkeeping.
  always_ff @(posedge clk_i) begin
    cls_q        <= cls_d;
    out_status_q <= out_status_d;
    out_class_q  <= out_class_d;
    out_name_q   <= out_name_d;
    out_date_q   <= out_date_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_class_o     = out_class_q;
  assign out_name_tag_o  = out_name_q;
  assign out_date_word_o = out_date_q;
  assign last_of_run_o   = out_last_q;

  // A pop is only started with pops left and an entry stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (run_q != '0 && fill_stat_i.any))
    else $error("pop started with nothing to serve");

  // Sending the marked word of a run returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && last_q) |=> (state_q == S_IDLE))
    else $error("run did not end after its last word");

  // A served word never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && !out_ready_i) |=> (state_q == S_EMIT))
    else $error("sequencer left send state while output stalled");

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import pcss_pkg::*;

  // Words that the block returns, as the testbench predicts them.
  typedef struct packed {
    stat_e            status;
    cls_t             cls;
    logic [TAG_W-1:0] name_tag;
    logic [TAG_W-1:0] date_word;
    logic             last_of_run;
  } served_word_t;

  localparam int unsigned STALL_LIMIT = 400;
  localparam int unsigned END_PAUSE   = 20;
  localparam int unsigned RAND_ITEMS  = 145;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               req_type_i;
  logic [CLS_W-1:0]   entry_class_i;
  logic [TAG_W-1:0]   name_tag_i;
  logic [TAG_W-1:0]   date_word_i;
  logic [COUNT_W-1:0] serve_count_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               out_status_o;
  logic [CLS_W-1:0]   out_class_o;
  logic [TAG_W-1:0]   out_name_tag_o;
  logic [TAG_W-1:0]   out_date_word_o;
  logic               last_of_run_o;

  // Predicted contents of the three stacks.
  logic [WORD_W-1:0]  entry_store [NUM_CLASSES][STACK_DEPTH];
  int unsigned        held_count [NUM_CLASSES];
  served_word_t       pending_words [$];

  int unsigned        error_count;
  int unsigned        quiet_cycles;
  bit                 no_idle;

  priority_class_stack_server_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .entry_class_i   (entry_class_i),
    .name_tag_i      (name_tag_i),
    .date_word_i     (date_word_i),
    .serve_count_i   (serve_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_status_o    (out_status_o),
    .out_class_o     (out_class_o),
    .out_name_tag_o  (out_name_tag_o),
    .out_date_word_o (out_date_word_o),
    .last_of_run_o   (last_of_run_o)
  );

  // Clock with a period of ten units.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the words that one accepted request causes.
  task automatic predict_request(input logic kind, input cls_t cls,
                                 input logic [TAG_W-1:0] name_tag,
                                 input logic [TAG_W-1:0] date_word,
                                 input logic [COUNT_W-1:0] count);
    served_word_t w;
    int unsigned  pops;
    int unsigned  emitted;
    int           c;
    logic [WORD_W-1:0] entry;
    emitted = 0;
    if (kind == REQ_PUSH) begin
      if (cls == CLS_INVALID) return;
      if (held_count[cls] >= STACK_DEPTH) begin
        // A full stack drops the entry and reports it.
        w = '{STAT_DROPPED, cls, name_tag, date_word, 1'b1};
        pending_words.push_back(w);
      end else begin
        entry_store[cls][held_count[cls]] = {name_tag, date_word};
        held_count[cls]++;
      end
      return;
    end
    pops = (count > MAX_RUN) ? MAX_RUN : count;
    for (int unsigned i = 0; i < pops; i++) begin
      // Take the top of the highest class that holds anything.
      c = -1;
      for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
        if (held_count[k] > 0) c = k;
      end
      if (c < 0) break;
      held_count[c]--;
      entry = entry_store[c][held_count[c]];
      w = '{STAT_SERVED, cls_t'(c), entry[WORD_W-1:TAG_W], entry[TAG_W-1:0], 1'b0};
      pending_words.push_back(w);
      emitted++;
    end
    if (emitted > 0) pending_words[pending_words.size() - 1].last_of_run = 1'b1;
  endtask

  // Offer one request word after a random gap and wait until it is taken.
  task automatic send_request(input logic kind, input cls_t cls,
                              input logic [TAG_W-1:0] name_tag,
                              input logic [TAG_W-1:0] date_word,
                              input logic [COUNT_W-1:0] count);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    entry_class_i <= cls;
    name_tag_i    <= name_tag;
    date_word_i   <= date_word;
    serve_count_i <= count;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(kind, cls, name_tag, date_word, count);
  endtask

  // A push carries a random count and a serve random payloads, as neither is used.
  task automatic push_entry(input cls_t cls, input logic [TAG_W-1:0] name_tag,
                            input logic [TAG_W-1:0] date_word);
    send_request(REQ_PUSH, cls, name_tag, date_word, COUNT_W'($urandom));
  endtask

  task automatic serve_entries(input logic [COUNT_W-1:0] count);
    send_request(REQ_SERVE, cls_t'($urandom), $urandom, $urandom, count);
  endtask

  function automatic void check_field(input string field, input logic [TAG_W-1:0] want,
                                      input logic [TAG_W-1:0] got);
    if (want !== got) begin
      $display("%0t: mismatch in %s: expected %h, actual %h", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Receiver: random stalls, and each accepted word is checked against the oldest prediction.
  initial begin : receiver
    int unsigned  stall;
    served_word_t want;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual status %h class %h %h %h last %h",
                 $time, out_status_o, out_class_o, out_name_tag_o, out_date_word_o,
                 last_of_run_o);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("out_status", want.status, out_status_o);
        check_field("out_class", want.cls, out_class_o);
        check_field("out_name_tag", want.name_tag, out_name_tag_o);
        check_field("out_date_word", want.date_word, out_date_word_o);
        check_field("last_of_run", want.last_of_run, last_of_run_o);
      end
    end
  end

  // Watchdog: the run ends if nothing is accepted on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, quiet_cycles);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Payload extremes, then pops from the top and a count above the cap.
  task automatic test_push_extremes();
    push_entry(CLS_HIGH, '0, '0);
    push_entry(CLS_LOW, '1, '1);
    push_entry(CLS_MID, $urandom, $urandom);
    serve_entries(COUNT_W'(1));
    serve_entries('1);
  endtask

  // Class 3 pushes, zero counts and serves on empty stacks give no word.
  task automatic test_ignored_and_empty();
    push_entry(CLS_INVALID, $urandom, $urandom);
    serve_entries('0);
    serve_entries(COUNT_W'(3));
  endtask

  // Fill one stack back to back, then push once more to see the drop.
  task automatic test_full_stack_drop();
    no_idle = 1'b1;
    for (int i = 0; i < STACK_DEPTH; i++) push_entry(CLS_MID, $urandom, $urandom);
    push_entry(CLS_MID, '1, '1);
    no_idle = 1'b0;
  endtask

  // Mostly pushes and short serves, with a favoured class so stacks fill at times.
  task automatic test_random_traffic();
    int unsigned pick;
    cls_t        focus;
    cls_t        cls;
    focus = CLS_HIGH;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) focus = cls_t'($urandom_range(0, 2));
      no_idle = (i >= 60 && i < 100);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        cls = ($urandom_range(0, 9) < 7) ? focus : cls_t'($urandom_range(0, 2));
        push_entry(cls, $urandom, $urandom);
      end else if (pick < 64) begin
        push_entry(CLS_INVALID, $urandom, $urandom);
      end else if (pick < 90) begin
        serve_entries(COUNT_W'($urandom_range(1, 8)));
      end else if (pick < 93) begin
        serve_entries('0);
      end else if (pick < 96) begin
        serve_entries(COUNT_W'(MAX_RUN));
      end else begin
        serve_entries(COUNT_W'($urandom_range(MAX_RUN + 1, 127)));
      end
    end
    no_idle = 1'b0;
    // Drain whatever is left on the stacks.
    serve_entries(COUNT_W'(MAX_RUN));
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_PUSH;
    entry_class_i = CLS_HIGH;
    name_tag_i    = '0;
    date_word_i   = '0;
    serve_count_i = '0;
    error_count   = 0;
    quiet_cycles  = 0;
    no_idle       = 1'b0;
    foreach (held_count[c]) held_count[c] = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_push_extremes();
    test_ignored_and_empty();
    test_full_stack_drop();
    test_random_traffic();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (END_PAUSE) @(posedge clk_i);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
